// File: hdl/lzp_pkg.sv
package lzp_pkg;

    localparam int HIST_DEPTH = 65536;
    localparam int POS_BITS   = 24;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);
    localparam int HASH_AW    = 16;
    localparam int HASH_DEPTH = 1 << HASH_AW;
    localparam int HENT_W     = POS_BITS + 1;

    localparam logic [3:0] HDR_SIZE_END = 4'd4;
    localparam logic [3:0] HDR_SKIP_END = 4'd6;
    localparam logic [3:0] HDR_LAST_LIT = 4'd9;
    localparam logic [3:0] BODY_IDX     = 4'd10;
    localparam logic [3:0] NO_FLAG      = 4'd8;
    localparam logic [3:0] FIRST_BIT    = 4'd7;
    localparam logic [31:0] FIXED_BYTES = 32'd6;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH_RD,
        ST_HASH_CHK,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_PUSH
    } state_t;

    typedef struct packed {
        logic [31:0] out_bytes;
        logic [2:0]  out_count;
        logic        out_last;
        logic        chunk_end;
        logic [1:0]  trim;
        logic        error_flag;
    } res_t;

    function automatic logic [HASH_AW-1:0] lzp_hash(input logic [31:0] c);
        lzp_hash = HASH_AW'((c >> 15) ^ c);
    endfunction

endpackage

// File: hdl/lzp_in_if.sv
interface lzp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

// File: hdl/lzp_out_if.sv
interface lzp_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_bytes;
    logic [2:0]  out_count;
    logic        out_last;
    logic        chunk_end;
    logic [1:0]  trim;
    logic        error_flag;

    modport source (output valid, output out_bytes, output out_count, output out_last,
                    output chunk_end, output trim, output error_flag, input ready);
    modport sink (input valid, input out_bytes, input out_count, input out_last,
                  input chunk_end, input trim, input error_flag, output ready);
endinterface

// File: hdl/lzp_ram.sv
module lzp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // read returns the old word on a same-address write
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end
endmodule

// File: hdl/lzp_out_stage.sv
module lzp_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  lzp_pkg::res_t     res,
    output logic              free,
    lzp_out_if.source         out_ch
);
    logic          valid_reg, valid_next;
    lzp_pkg::res_t data_reg;

    assign free = !valid_reg || out_ch.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res;
        end
    end

    assign out_ch.valid      = valid_reg;
    assign out_ch.out_bytes  = data_reg.out_bytes;
    assign out_ch.out_count  = data_reg.out_count;
    assign out_ch.out_last   = data_reg.out_last;
    assign out_ch.chunk_end  = data_reg.chunk_end;
    assign out_ch.trim       = data_reg.trim;
    assign out_ch.error_flag = data_reg.error_flag;
endmodule

// File: hdl/lzp_chunk_decompressor.sv
// Channel  Dir  Fields                                             Handshake
// in_ch    in   in_byte[7:0]                                       valid/ready
// out_ch   out  out_bytes, out_count, out_last, chunk_end,         valid/ready
//               trim, error_flag
//
// Header and flag bytes push a request only for a fixed literal or a chunk end.
// Token: hash lookup (ST_HASH_RD, then ST_HASH_CHK), then a literal pushes; a match of length L
// copies byte by byte (history RAM read, then write back) with one push per 4 bytes.
// After reset the hash table is swept clear, with in_ch not ready.
// in_ch is ready only while the sequencer idles; a stalled out_ch holds the
// sequencer at its next request, one finished request can wait in the output stage.
module lzp_chunk_decompressor (
    input  logic       clk,
    input  logic       rst_n,
    lzp_in_if.sink     in_ch,
    lzp_out_if.source  out_ch
);
    localparam int PB = lzp_pkg::POS_BITS;
    localparam int HA = lzp_pkg::HIST_AW;

    lzp_pkg::state_t state_reg, state_next;
    logic [PB-1:0]  pos_reg, pos_next;
    logic [31:0]    last4_reg, last4_next;
    logic [3:0]     hidx_reg, hidx_next;
    logic [31:0]    left_reg, left_next;
    logic [7:0]     flags_reg, flags_next;
    logic [3:0]     bidx_reg, bidx_next;
    logic           err_reg, err_next;
    logic [7:0]     byte_reg, byte_next;
    logic           tokbit_reg, tokbit_next;
    logic           ended_reg, ended_next;
    logic [1:0]     trim_reg, trim_next;
    logic [PB-1:0]  src_reg, src_next;
    logic [7:0]     cnt_reg, cnt_next;
    logic [31:0]    word_reg, word_next;
    logic [2:0]     wcnt_reg, wcnt_next;
    logic [lzp_pkg::HASH_AW-1:0] clr_reg, clr_next;

    logic                        hist_we;
    logic [7:0]                  hist_rdata;
    logic                        ht_we;
    logic [lzp_pkg::HASH_AW-1:0] ht_waddr;
    logic [lzp_pkg::HENT_W-1:0]  ht_wdata;
    logic [lzp_pkg::HENT_W-1:0]  ht_rdata;
    logic [lzp_pkg::HASH_AW-1:0] hash;

    logic          emit_en;
    logic [7:0]    emit_byte;
    logic          out_load;
    logic          out_free;
    lzp_pkg::res_t res;

    logic [PB-1:0] ent_pos;
    logic [PB-1:0] back;
    logic [PB-1:0] ahead;
    logic          match_ok;
    logic [31:0]   left_dec;
    logic [31:0]   left_lit;
    logic          accept;

    assign hash     = lzp_pkg::lzp_hash(last4_reg);
    assign ent_pos  = ht_rdata[PB-1:0];
    assign back     = pos_reg - ent_pos;
    assign ahead    = ent_pos - pos_reg;
    assign match_ok = ht_rdata[lzp_pkg::HENT_W-1]
                      && ((back != '0 && 33'(back) <= 33'(lzp_pkg::HIST_DEPTH))
                          || 33'(ahead) <= 33'd3);
    assign left_dec = left_reg - 32'd1;
    assign left_lit = (left_reg > lzp_pkg::FIXED_BYTES) ? left_reg - lzp_pkg::FIXED_BYTES
                                                        : 32'd0;
    assign in_ch.ready = (state_reg == lzp_pkg::ST_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;

    assign ht_we    = (state_reg == lzp_pkg::ST_CLEAR) || (state_reg == lzp_pkg::ST_HASH_RD);
    assign ht_waddr = (state_reg == lzp_pkg::ST_CLEAR) ? clr_reg : hash;
    assign ht_wdata = (state_reg == lzp_pkg::ST_CLEAR) ? '0 : {1'b1, pos_reg};

    lzp_ram #(.WIDTH(lzp_pkg::HENT_W), .DEPTH(lzp_pkg::HASH_DEPTH)) u_hash_ram (
        .clk   (clk),
        .we    (ht_we),
        .waddr (ht_waddr),
        .wdata (ht_wdata),
        .raddr (hash),
        .rdata (ht_rdata)
    );

    lzp_ram #(.WIDTH(8), .DEPTH(lzp_pkg::HIST_DEPTH)) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (HA'(pos_reg)),
        .wdata (emit_byte),
        .raddr (HA'(src_reg)),
        .rdata (hist_rdata)
    );

    assign res.out_bytes  = word_reg;
    assign res.out_count  = wcnt_reg;
    assign res.out_last   = (cnt_reg == 8'd0);
    assign res.chunk_end  = ended_reg;
    assign res.trim       = ended_reg ? trim_reg : 2'd0;
    assign res.error_flag = err_reg;

    lzp_out_stage u_out (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (out_load),
        .res    (res),
        .free   (out_free),
        .out_ch (out_ch)
    );

    always_comb
    begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        last4_next  = last4_reg;
        hidx_next   = hidx_reg;
        left_next   = left_reg;
        flags_next  = flags_reg;
        bidx_next   = bidx_reg;
        err_next    = err_reg;
        byte_next   = byte_reg;
        tokbit_next = tokbit_reg;
        ended_next  = ended_reg;
        trim_next   = trim_reg;
        src_next    = src_reg;
        cnt_next    = cnt_reg;
        word_next   = word_reg;
        wcnt_next   = wcnt_reg;
        clr_next    = clr_reg;
        emit_en     = 1'b0;
        emit_byte   = in_ch.in_byte;
        out_load    = 1'b0;

        unique case (state_reg)
            lzp_pkg::ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == '1)
                begin
                    state_next = lzp_pkg::ST_IDLE;
                end
            end
            lzp_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (hidx_reg < lzp_pkg::HDR_SIZE_END)
                    begin
                        // little-endian size field
                        left_next = (hidx_reg == 4'd0) ? 32'(in_ch.in_byte)
                                  : left_reg | (32'(in_ch.in_byte) << {hidx_reg[1:0], 3'b000});
                        hidx_next = hidx_reg + 4'd1;
                    end
                    else if (hidx_reg < lzp_pkg::HDR_SKIP_END)
                    begin
                        hidx_next = hidx_reg + 4'd1;
                    end
                    else if (hidx_reg < lzp_pkg::BODY_IDX)
                    begin
                        emit_en    = 1'b1;
                        hidx_next  = hidx_reg + 4'd1;
                        ended_next = 1'b0;
                        trim_next  = pos_reg[1:0] + 2'd1;
                        cnt_next   = 8'd0;
                        state_next = lzp_pkg::ST_PUSH;
                        if (hidx_reg == lzp_pkg::HDR_LAST_LIT)
                        begin
                            left_next = left_lit;
                            if (left_lit == 32'd0)
                            begin
                                ended_next = 1'b1;
                                hidx_next  = 4'd0;
                                bidx_next  = lzp_pkg::NO_FLAG;
                            end
                        end
                    end
                    else
                    begin
                        left_next  = left_dec;
                        ended_next = (left_dec == 32'd0);
                        if (left_dec == 32'd0)
                        begin
                            hidx_next = 4'd0;
                        end
                        if (bidx_reg[3])
                        begin
                            flags_next = in_ch.in_byte;
                            bidx_next  = lzp_pkg::FIRST_BIT;
                            if (left_dec == 32'd0)
                            begin
                                bidx_next  = lzp_pkg::NO_FLAG;
                                trim_next  = pos_reg[1:0];
                                cnt_next   = 8'd0;
                                state_next = lzp_pkg::ST_PUSH;
                            end
                        end
                        else
                        begin
                            byte_next   = in_ch.in_byte;
                            tokbit_next = flags_reg[bidx_reg[2:0]];
                            bidx_next   = (bidx_reg == 4'd0 || left_dec == 32'd0)
                                          ? lzp_pkg::NO_FLAG : bidx_reg - 4'd1;
                            state_next  = lzp_pkg::ST_HASH_RD;
                        end
                    end
                end
            end
            lzp_pkg::ST_HASH_RD:
            begin
                // old entry read and new position written in the same cycle
                state_next = lzp_pkg::ST_HASH_CHK;
            end
            lzp_pkg::ST_HASH_CHK:
            begin
                cnt_next = 8'd0;
                if (!tokbit_reg)
                begin
                    emit_en    = 1'b1;
                    emit_byte  = byte_reg;
                    trim_next  = pos_reg[1:0] + 2'd1;
                    state_next = lzp_pkg::ST_PUSH;
                end
                else if (!match_ok)
                begin
                    err_next   = 1'b1;
                    trim_next  = pos_reg[1:0];
                    state_next = (ended_reg || !err_reg) ? lzp_pkg::ST_PUSH
                                                         : lzp_pkg::ST_IDLE;
                end
                else
                begin
                    trim_next = pos_reg[1:0] + byte_reg[1:0];
                    src_next  = ent_pos;
                    cnt_next  = byte_reg;
                    if (byte_reg != 8'd0)
                    begin
                        state_next = lzp_pkg::ST_COPY_RD;
                    end
                    else
                    begin
                        state_next = ended_reg ? lzp_pkg::ST_PUSH : lzp_pkg::ST_IDLE;
                    end
                end
            end
            lzp_pkg::ST_COPY_RD:
            begin
                src_next   = src_reg + 1'b1;
                cnt_next   = cnt_reg - 8'd1;
                state_next = lzp_pkg::ST_COPY_WR;
            end
            lzp_pkg::ST_COPY_WR:
            begin
                emit_en    = 1'b1;
                emit_byte  = hist_rdata;
                state_next = (wcnt_reg == 3'd3 || cnt_reg == 8'd0) ? lzp_pkg::ST_PUSH
                                                                    : lzp_pkg::ST_COPY_RD;
            end
            lzp_pkg::ST_PUSH:
            begin
                if (out_free)
                begin
                    out_load  = 1'b1;
                    word_next = 32'd0;
                    wcnt_next = 3'd0;
                    if (cnt_reg == 8'd0)
                    begin
                        state_next = lzp_pkg::ST_IDLE;
                        if (ended_reg)
                        begin
                            pos_next  = {pos_reg[PB-1:2], 2'b00};
                            left_next = 32'd0;
                        end
                    end
                    else
                    begin
                        state_next = lzp_pkg::ST_COPY_RD;
                    end
                end
            end
            default:
            begin
                state_next = lzp_pkg::ST_IDLE;
            end
        endcase

        hist_we = emit_en;
        if (emit_en)
        begin
            pos_next   = pos_reg + 1'b1;
            last4_next = {last4_reg[23:0], emit_byte};
            word_next  = word_reg | (32'(emit_byte) << {wcnt_reg, 3'b000});
            wcnt_next  = wcnt_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lzp_pkg::ST_CLEAR;
            pos_reg   <= '0;
            last4_reg <= '0;
            hidx_reg  <= '0;
            left_reg  <= '0;
            flags_reg <= '0;
            bidx_reg  <= lzp_pkg::NO_FLAG;
            err_reg   <= 1'b0;
            ended_reg <= 1'b0;
            cnt_reg   <= '0;
            wcnt_reg  <= '0;
            word_reg  <= '0;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            last4_reg <= last4_next;
            hidx_reg  <= hidx_next;
            left_reg  <= left_next;
            flags_reg <= flags_next;
            bidx_reg  <= bidx_next;
            err_reg   <= err_next;
            ended_reg <= ended_next;
            cnt_reg   <= cnt_next;
            wcnt_reg  <= wcnt_next;
            word_reg  <= word_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg   <= byte_next;
        tokbit_reg <= tokbit_next;
        trim_reg   <= trim_next;
        src_reg    <= src_next;
    end

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> out_free)
        else $error("result pushed into a full output stage");

    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg |=> err_reg)
        else $error("error flag cleared");

    a_word_fill: assert property (@(posedge clk) disable iff (!rst_n)
        wcnt_reg <= 3'd4)
        else $error("output word overfilled");

    a_copy_flow: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == lzp_pkg::ST_COPY_WR |=>
            (state_reg == lzp_pkg::ST_PUSH || state_reg == lzp_pkg::ST_COPY_RD))
        else $error("copy sequence broken");

    a_align: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lzp_pkg::ST_PUSH && out_free && cnt_reg == 8'd0 && ended_reg)
            |=> pos_reg[1:0] == 2'b00)
        else $error("position not aligned at chunk end");
endmodule

// File: dv/lzp_chunk_decompressor_tb.sv
`timescale 1ns / 1ps

module lzp_chunk_decompressor_tb;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int TARGET_BYTES   = 260;

    typedef struct {
        logic [7:0]    b;
        bit            typed;
        lzp_pkg::res_t r;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;

    lzp_in_if  in_ch ();
    lzp_out_if out_ch ();

    lzp_chunk_decompressor u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // decoder state mirror
    bit                           hash_valid [lzp_pkg::HASH_DEPTH];
    logic [lzp_pkg::POS_BITS-1:0] hash_pos   [lzp_pkg::HASH_DEPTH];
    logic [7:0]                   hist_mem   [lzp_pkg::HIST_DEPTH];
    bit                           hist_wr    [lzp_pkg::HIST_DEPTH];
    logic [lzp_pkg::POS_BITS-1:0] wr_pos;
    logic [31:0]                  tail_word;
    int unsigned                  hdr_idx;
    logic [31:0]                  chunk_rem;
    logic [7:0]                   flag_byte;
    int unsigned                  flag_idx;
    bit                           sticky_err;
    logic [7:0]                   decoded [$];

    logic [7:0]     byte_q [$];
    lzp_pkg::res_t  expected_q [$];
    stim_row_t      dir_rows [$];
    int             errors;
    int             idle_cycles;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic lzp_pkg::res_t mk_res(logic [31:0] w, logic [2:0] c, logic l,
                                             logic e, logic [1:0] t, logic er);
        lzp_pkg::res_t r;
        r.out_bytes  = w;
        r.out_count  = c;
        r.out_last   = l;
        r.chunk_end  = e;
        r.trim       = t;
        r.error_flag = er;
        return r;
    endfunction

    function automatic logic [15:0] tail_hash();
        logic [31:0] x;
        x = (tail_word >> 15) ^ tail_word;
        return x[15:0];
    endfunction

    function automatic bit match_src_ok(logic [15:0] h);
        logic [lzp_pkg::POS_BITS-1:0] back;
        logic [lzp_pkg::POS_BITS-1:0] ahead;
        back  = wr_pos - hash_pos[h];
        ahead = hash_pos[h] - wr_pos;
        return hash_valid[h] && ((back >= 1 && int'(back) <= lzp_pkg::HIST_DEPTH)
                                 || ahead <= 3);
    endfunction

    // true if a copy of len bytes from src never reads a slot before it has been written
    function automatic bit copy_is_safe(logic [lzp_pkg::POS_BITS-1:0] src, int len);
        logic [lzp_pkg::POS_BITS-1:0] p;
        logic [lzp_pkg::POS_BITS-1:0] d;
        for (int i = 0; i < len; i++)
        begin
            p = src + lzp_pkg::POS_BITS'(i);
            d = p - wr_pos;
            if (!hist_wr[p[lzp_pkg::HIST_AW-1:0]] && !(int'(d) < i))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void put_byte(logic [7:0] b);
        hist_mem[wr_pos[lzp_pkg::HIST_AW-1:0]] = b;
        hist_wr[wr_pos[lzp_pkg::HIST_AW-1:0]]  = 1'b1;
        wr_pos    = wr_pos + 1'b1;
        tail_word = {tail_word[23:0], b};
        decoded.push_back(b);
    endfunction

    function automatic bit run_token(logic [7:0] b);
        logic [15:0]                  h;
        logic [lzp_pkg::POS_BITS-1:0] src;
        bit                           ok;
        bit                           fresh;
        h   = tail_hash();
        ok  = match_src_ok(h);
        src = hash_pos[h];
        hash_valid[h] = 1'b1;
        hash_pos[h]   = wr_pos;
        if (!flag_byte[flag_idx[2:0]])
        begin
            put_byte(b);
            return 1'b0;
        end
        if (!ok)
        begin
            fresh      = !sticky_err;
            sticky_err = 1'b1;
            return fresh;
        end
        for (int i = 0; i < int'(b); i++)
        begin
            put_byte(hist_mem[src[lzp_pkg::HIST_AW-1:0]]);
            src = src + 1'b1;
        end
        return 1'b0;
    endfunction

    // advance the mirror by one compressed byte and queue the results it yields
    function automatic void decode_byte(logic [7:0] b);
        bit       ended;
        bit       new_err;
        logic [1:0] trim_v;
        int       nres;
        int       cnt;
        logic [31:0] w;
        ended   = 1'b0;
        new_err = 1'b0;
        trim_v  = 2'd0;
        decoded.delete();
        if (hdr_idx < 4)
        begin
            if (hdr_idx == 0)
                chunk_rem = '0;
            chunk_rem = chunk_rem | (32'(b) << (8 * hdr_idx));
            hdr_idx++;
        end
        else if (hdr_idx < 6)
            hdr_idx++;
        else if (hdr_idx < lzp_pkg::BODY_IDX)
        begin
            put_byte(b);
            hdr_idx++;
            if (hdr_idx == lzp_pkg::BODY_IDX)
            begin
                chunk_rem = (chunk_rem > lzp_pkg::FIXED_BYTES)
                            ? chunk_rem - lzp_pkg::FIXED_BYTES : 32'd0;
                if (chunk_rem == 0)
                    ended = 1'b1;
            end
        end
        else
        begin
            chunk_rem = chunk_rem - 1;
            if (flag_idx > 7)
            begin
                flag_byte = b;
                flag_idx  = lzp_pkg::FIRST_BIT;
            end
            else
            begin
                new_err  = run_token(b);
                flag_idx = (flag_idx == 0) ? lzp_pkg::NO_FLAG : flag_idx - 1;
            end
            if (chunk_rem == 0)
                ended = 1'b1;
        end
        if (ended)
        begin
            trim_v    = wr_pos[1:0];
            wr_pos[1:0] = 2'b00;
            hdr_idx   = 0;
            flag_idx  = lzp_pkg::NO_FLAG;
            chunk_rem = '0;
        end
        nres = (decoded.size() + 3) / 4;
        if (nres == 0 && (ended || new_err))
            nres = 1;
        for (int k = 0; k < nres; k++)
        begin
            w   = '0;
            cnt = 0;
            for (int j = 0; j < 4 && k * 4 + j < decoded.size(); j++)
            begin
                w[8*j +: 8] = decoded[k*4 + j];
                cnt++;
            end
            expected_q.push_back(mk_res(w, 3'(cnt), k + 1 == nres, ended, trim_v,
                                        sticky_err));
        end
    endfunction

    // match lengths that would read never-written history become zero-length
    function automatic logic [7:0] fix_token(logic [7:0] b);
        logic [15:0] h;
        if (hdr_idx < lzp_pkg::BODY_IDX || flag_idx > 7 || !flag_byte[flag_idx[2:0]])
            return b;
        h = tail_hash();
        if (match_src_ok(h) && !copy_is_safe(hash_pos[h], int'(b)))
            return 8'd0;
        return b;
    endfunction

    function automatic void add_byte(logic [7:0] b);
        logic [7:0] v;
        v = fix_token(b);
        byte_q.push_back(v);
        decode_byte(v);
    endfunction

    function automatic logic [7:0] pick_literal();
        logic [7:0] alpha [4] = '{8'h41, 8'h42, 8'h00, 8'hFF};
        if ($urandom_range(0, 1))
            return alpha[$urandom_range(0, 3)];
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return 8'($urandom_range(0, 8));
        if (r < 95)
            return 8'($urandom_range(9, 40));
        return 8'd255;
    endfunction

    function automatic void gen_chunk();
        logic [31:0] size;
        if ($urandom_range(0, 4) == 0)
            size = $urandom_range(0, 6);
        else
            size = 6 + $urandom_range(1, 40);
        for (int i = 0; i < 4; i++)
            add_byte(size[8*i +: 8]);
        add_byte(8'($urandom_range(0, 255)));
        add_byte(8'($urandom_range(0, 255)));
        for (int i = 0; i < 4; i++)
            add_byte(pick_literal());
        while (hdr_idx == lzp_pkg::BODY_IDX)
        begin
            if (flag_idx > 7)
                add_byte(8'($urandom_range(0, 255)));
            else if (flag_byte[flag_idx[2:0]])
                add_byte(pick_length());
            else
                add_byte(pick_literal());
        end
    endfunction

    function automatic void add_row(logic [7:0] b);
        stim_row_t r;
        r.b     = b;
        r.typed = 1'b0;
        r.r     = '0;
        dir_rows.push_back(r);
    endfunction

    function automatic void add_typed(logic [7:0] b, lzp_pkg::res_t exp_r);
        stim_row_t r;
        r.b     = b;
        r.typed = 1'b1;
        r.r     = exp_r;
        dir_rows.push_back(r);
    endfunction

    function automatic int draw_gap(int n);
        if ((n / 32) % 3 == 0)
            return 0;
        return $urandom_range(0, 15);
    endfunction

    function automatic void build_stimulus();
        int before_n;
        for (int i = 0; i < lzp_pkg::HASH_DEPTH; i++)
            hash_valid[i] = 1'b0;
        for (int i = 0; i < lzp_pkg::HIST_DEPTH; i++)
            hist_wr[i] = 1'b0;
        wr_pos     = '0;
        tail_word  = '0;
        hdr_idx    = 0;
        chunk_rem  = '0;
        flag_byte  = '0;
        flag_idx   = lzp_pkg::NO_FLAG;
        sticky_err = 1'b0;

        // size 6: only the fixed bytes, chunk ends on the last literal
        add_row(8'h06); add_row(8'h00); add_row(8'h00); add_row(8'h00);
        add_row(8'h00); add_row(8'hFF);
        add_typed(8'h00, mk_res(32'h00, 3'd1, 1'b1, 1'b0, 2'd0, 1'b0));
        add_typed(8'hFF, mk_res(32'hFF, 3'd1, 1'b1, 1'b0, 2'd0, 1'b0));
        add_typed(8'h80, mk_res(32'h80, 3'd1, 1'b1, 1'b0, 2'd0, 1'b0));
        add_typed(8'h01, mk_res(32'h01, 3'd1, 1'b1, 1'b1, 2'd0, 1'b0));
        // body: flag, long match on empty entry, zero-length match, literals
        add_row(8'h0B); add_row(8'h00); add_row(8'h00); add_row(8'h00);
        add_row(8'hA5); add_row(8'h5A);
        add_row(8'h41); add_row(8'h42); add_row(8'h41); add_row(8'h42);
        add_row(8'hC0); add_row(8'hFF); add_row(8'h00); add_row(8'h7E); add_row(8'h81);

        foreach (dir_rows[i])
        begin
            before_n = expected_q.size();
            add_byte(dir_rows[i].b);
            if (dir_rows[i].typed)
            begin
                while (expected_q.size() > before_n)
                    void'(expected_q.pop_back());
                expected_q.push_back(dir_rows[i].r);
            end
        end
        while (byte_q.size() < TARGET_BYTES)
            gen_chunk();
    endfunction

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge clk)
    begin
        lzp_pkg::res_t want;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual %h %0d", $time,
                             out_ch.out_bytes, out_ch.out_count);
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("out_bytes", want.out_bytes, out_ch.out_bytes);
                    check_field("out_count", 32'(want.out_count), 32'(out_ch.out_count));
                    check_field("out_last", 32'(want.out_last), 32'(out_ch.out_last));
                    check_field("chunk_end", 32'(want.chunk_end), 32'(out_ch.chunk_end));
                    check_field("trim", 32'(want.trim), 32'(out_ch.trim));
                    check_field("error_flag", 32'(want.error_flag),
                                32'(out_ch.error_flag));
                end
            end
            if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("lzp_chunk_decompressor_tb: done, errors");
                $finish;
            end
        end
    end

    // result side: random stall before each request
    initial begin
        int n;
        int stall;
        n = 0;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = draw_gap(n + 16);
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!out_ch.valid)
                @(posedge clk);
            n++;
        end
    end

    initial begin
        int gap;
        errors       = 0;
        idle_cycles  = 0;
        rst_n        = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.in_byte = 8'h00;
        build_stimulus();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < byte_q.size(); i++)
        begin
            gap = draw_gap(i);
            if (gap > 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_ch.valid   <= 1'b1;
            in_ch.in_byte <= byte_q[i];
            @(posedge clk);
            while (!in_ch.ready)
                @(posedge clk);
        end
        in_ch.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (600) @(posedge clk);
        if (errors == 0 && expected_q.size() == 0)
            $display("lzp_chunk_decompressor_tb: done, clean");
        else
            $display("lzp_chunk_decompressor_tb: done, errors");
        $finish;
    end

endmodule
